// File: sv/pop_pkg.sv
// Shared constants, register codes and control types of the path option payoff block.
`default_nettype none

package pop_pkg;

  localparam int PATH_MAX_DEF   = 65536;
  localparam int PRICE_BITS_DEF = 32;

  localparam int SAMPLE_W = 32;
  localparam int PAYOFF_W = 32;
  localparam int SUM_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [PAYOFF_W-1:0] ONE_Q16 = 32'h0001_0000;

  localparam logic [CFG_IDX_W-1:0] REG_PAYOFF_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IS_CALL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BARRIER_KIND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HIGH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BARRIER_LEVEL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REBATE        = 3'd7;

  localparam logic [2:0] KIND_VANILLA        = 3'd0;
  localparam logic [2:0] KIND_DIGITAL        = 3'd1;
  localparam logic [2:0] KIND_DOUBLE_DIGITAL = 3'd2;
  localparam logic [2:0] KIND_ASIAN_FIXED    = 3'd3;
  localparam logic [2:0] KIND_ASIAN_FLOAT    = 3'd4;
  localparam logic [2:0] KIND_BARRIER        = 3'd5;
  localparam logic [2:0] KIND_LOOKBACK       = 3'd6;

  localparam logic [1:0] BARRIER_UP_IN    = 2'd0;
  localparam logic [1:0] BARRIER_UP_OUT   = 2'd1;
  localparam logic [1:0] BARRIER_DOWN_IN  = 2'd2;
  localparam logic [1:0] BARRIER_DOWN_OUT = 2'd3;

  typedef struct packed {
    logic sample_take;
    logic div_start;
    logic div_step;
    logic pay_load;
  } pop_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } pop_status_t;

endpackage

`default_nettype wire

// File: sv/pop_ifs.sv
// Valid/ready channel interfaces for price samples, payoff results and register writes.
`default_nettype none

interface pop_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] price_sample;
  logic        path_end;
  modport source (output valid, price_sample, path_end, input ready);
  modport sink (input valid, price_sample, path_end, output ready);
endinterface

interface pop_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] payoff;
  modport source (output valid, payoff, input ready);
  modport sink (input valid, payoff, output ready);
endinterface

interface pop_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/pop_ctrl.sv
// Controller state machine: sample intake, mean division and payoff hand-off.
`default_nettype none

module pop_ctrl
  import pop_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_path_end,
  input  wire pop_status_t status,
  output pop_cmd_t         cmd,
  output logic             in_ready
);

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_PAY = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_RUN: begin
        in_ready = 1'b1;
        cmd.sample_take = in_valid;
        if (in_valid && in_path_end) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_PAY;
        end
      end
      ST_PAY: begin
        if (status.out_free) begin
          cmd.pay_load = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/pop_datapath.sv
// Datapath: registers, path statistics, bit-serial mean divider and payoff result register.
`default_nettype none

module pop_datapath
  import pop_pkg::*;
#(
  parameter int PATH_MAX   = PATH_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pop_cmd_t              cmd,
  output pop_status_t                status,
  input  wire logic [SAMPLE_W-1:0]   price_sample,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [PAYOFF_W-1:0]        payoff
);

  localparam int SB = (PRICE_BITS < SAMPLE_W) ? PRICE_BITS : SAMPLE_W;
  localparam int CW = $clog2(PATH_MAX + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(PATH_MAX);

  logic [2:0]    payoff_kind;
  logic          is_call;
  logic [1:0]    barrier_kind;
  logic [SB-1:0] strike;
  logic [SB-1:0] level_low;
  logic [SB-1:0] level_high;
  logic [SB-1:0] barrier_level;
  logic [PAYOFF_W-1:0] rebate;

  logic [SB-1:0]    path_max;
  logic [SB-1:0]    path_min;
  logic [SUM_W-1:0] path_sum;
  logic [CW-1:0]    sample_count;
  logic [SB-1:0]    last_sample;

  logic [SB-1:0]    s_in;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_next;

  logic [SUM_W-1:0]     div_quo;
  logic [CW-1:0]        div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CW:0]          div_trial;
  logic                 div_bit;

  logic [SB-1:0]       mean;
  logic                met;
  logic [PAYOFF_W-1:0] result;

  function automatic logic [SB-1:0] pos_diff(input logic [SB-1:0] a, input logic [SB-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [PAYOFF_W-1:0] vanilla(input logic [SB-1:0] s,
                                                  input logic [SB-1:0] k,
                                                  input logic call);
    return PAYOFF_W'(call ? pos_diff(s, k) : pos_diff(k, s));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      payoff_kind   <= KIND_VANILLA;
      is_call       <= 1'b1;
      barrier_kind  <= BARRIER_UP_IN;
      strike        <= '0;
      level_low     <= '0;
      level_high    <= '0;
      barrier_level <= '0;
      rebate        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAYOFF_KIND:   payoff_kind <= cfg_data[2:0];
        REG_IS_CALL:       is_call <= cfg_data[0];
        REG_BARRIER_KIND:  barrier_kind <= cfg_data[1:0];
        REG_STRIKE:        strike <= cfg_data[SB-1:0];
        REG_LEVEL_LOW:     level_low <= cfg_data[SB-1:0];
        REG_LEVEL_HIGH:    level_high <= cfg_data[SB-1:0];
        REG_BARRIER_LEVEL: barrier_level <= cfg_data[SB-1:0];
        REG_REBATE:        rebate <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_in = price_sample[SB-1:0];
  assign sum_ext = {1'b0, path_sum} + (SUM_W + 1)'(s_in);

  always_comb begin
    sum_next = path_sum;
    if (sample_count < COUNT_MAX) begin
      sum_next = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.pay_load) begin
      path_max     <= '0;
      path_min     <= '1;
      path_sum     <= '0;
      sample_count <= '0;
    end else if (cmd.sample_take) begin
      if (s_in > path_max) path_max <= s_in;
      if (s_in < path_min) path_min <= s_in;
      path_sum <= sum_next;
      if (sample_count < COUNT_MAX) sample_count <= sample_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_take) begin
      last_sample <= s_in;
    end
  end

  // Restoring division, one quotient bit per step; the dividend shifts out as the quotient shifts in.
  assign div_trial = {div_rem, div_quo[SUM_W-1]};
  assign div_bit = div_trial >= {1'b0, sample_count};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_quo <= sum_next;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_quo <= {div_quo[SUM_W-2:0], div_bit};
      div_rem <= div_bit ? CW'(div_trial - {1'b0, sample_count}) : div_trial[CW-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign status.div_last = cmd.div_step && (div_cnt == DIV_CNT_W'(SUM_W - 1));
  assign status.out_free = !out_valid || out_ready;

  assign mean = div_quo[SB-1:0];

  always_comb begin
    case (barrier_kind)
      BARRIER_UP_IN:   met = path_max > barrier_level;
      BARRIER_UP_OUT:  met = path_max < barrier_level;
      BARRIER_DOWN_IN: met = path_min < barrier_level;
      default:         met = path_min > barrier_level;
    endcase
  end

  always_comb begin
    case (payoff_kind)
      KIND_VANILLA: result = vanilla(last_sample, strike, is_call);
      KIND_DIGITAL: begin
        if (is_call) result = (last_sample > strike) ? ONE_Q16 : '0;
        else result = (last_sample < strike) ? ONE_Q16 : '0;
      end
      KIND_DOUBLE_DIGITAL: begin
        if (is_call) begin
          result = (last_sample > level_low && last_sample < level_high) ? ONE_Q16 : '0;
        end else begin
          result = (last_sample < level_low || last_sample > level_high) ? ONE_Q16 : '0;
        end
      end
      KIND_ASIAN_FIXED: result = vanilla(mean, strike, is_call);
      KIND_ASIAN_FLOAT: result = vanilla(last_sample, mean, is_call);
      KIND_BARRIER:     result = met ? vanilla(last_sample, strike, is_call) : rebate;
      KIND_LOOKBACK: begin
        result = is_call ? PAYOFF_W'(pos_diff(last_sample, path_min))
                         : PAYOFF_W'(pos_diff(path_max, last_sample));
      end
      default: result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pay_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pay_load) begin
      payoff <= result;
    end
  end

endmodule

`default_nettype wire

// File: sv/path_option_payoff.sv
// Top level of the path option payoff block: controller, datapath and channel wiring.
//
// Price samples are taken one beat per cycle while a path is in progress. The beat flagged
// path_end also takes part in the statistics; after it the block computes the arithmetic
// mean with a bit-serial divider, then forms the payoff and places it in the result
// register; the next path's first sample is taken only after that, and later still if the
// previous payoff has not yet been taken. Register writes are taken in any cycle outside
// reset and must only be issued while the block is idle.
`default_nettype none

module path_option_payoff
  import pop_pkg::*;
#(
  parameter int PATH_MAX   = PATH_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  pop_sample_if.sink     samples,
  pop_result_if.source   results,
  pop_cfg_if.sink        cfg
);

  pop_cmd_t    cmd;
  pop_status_t status;
  logic        in_ready;
  logic        out_valid;
  logic [PAYOFF_W-1:0] payoff;

  assign samples.ready = in_ready && !rst;
  assign cfg.ready = !rst;
  assign results.valid = out_valid;
  assign results.payoff = payoff;

  pop_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (samples.valid),
    .in_path_end (samples.path_end),
    .status      (status),
    .cmd         (cmd),
    .in_ready    (in_ready)
  );

  pop_datapath #(
    .PATH_MAX   (PATH_MAX),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .price_sample (samples.price_sample),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_ready    (results.ready),
    .out_valid    (out_valid),
    .payoff       (payoff)
  );

endmodule

`default_nettype wire

// File: sv/pop_checker.sv
// Port-level assertions for the path option payoff block and their bind.
`default_nettype none

module pop_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_path_end,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] payoff
);

  a_out_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(payoff))
    else $error("result payload changed while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_path_end |=> !in_ready)
    else $error("sample taken right after the last beat of a path");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while samples were being taken");

endmodule

bind path_option_payoff pop_checker u_pop_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .in_path_end (samples.path_end),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .payoff      (results.payoff)
);

`default_nettype wire
